FILE: hdl/wildcard_byte_pattern_scan_top_macros.svh
// Assertion macros shared by the wildcard byte pattern scan RTL.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_TOP_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_TOP_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define WBPS_ASSERT_SAME(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("same-cycle check failed");

// Condition a implies condition c in the following cycle.
`define WBPS_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

FILE: hdl/wbps_pkg.sv
// Shared constants for the wildcard byte pattern scan.
`default_nettype none

package wbps_pkg;

  localparam int DATA_W          = 8;
  localparam int ADDR_W          = 64;
  localparam int WORD_W          = 64;
  localparam int NUM_PWORDS      = 4;
  localparam int PAT_BYTES       = 32;
  localparam int CARE_W          = 32;
  localparam int LEN_W           = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int MAX_PATTERN_DEF = 32;
  localparam int OFFSET_BITS_DEF = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 3'd6;

endpackage

`default_nettype wire

FILE: hdl/wbps_in_if.sv
// Input byte channel of the pattern scan.
`default_nettype none

interface wbps_in_if;
  logic                          valid;
  logic                          ready;
  logic [wbps_pkg::DATA_W-1:0]   data_byte;
  logic                          byte_readable;
  logic                          last_byte;

  modport source (output valid, output data_byte, output byte_readable,
                  output last_byte, input ready);
  modport sink   (input valid, input data_byte, input byte_readable,
                  input last_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/wbps_out_if.sv
// Result channel of the pattern scan.
`default_nettype none

interface wbps_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [wbps_pkg::ADDR_W-1:0]   match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

FILE: hdl/wbps_match.sv
// Parallel compare of the byte window against the masked pattern.
`default_nettype none

module wbps_match #(
  parameter int Win = 32
) (
  input  logic [wbps_pkg::DATA_W-1:0]              win_bytes [Win],
  input  logic                                     win_rd    [Win],
  input  logic [wbps_pkg::PAT_BYTES*wbps_pkg::DATA_W-1:0] pattern,
  input  logic [wbps_pkg::CARE_W-1:0]              care,
  input  logic [wbps_pkg::LEN_W-1:0]               len,
  output logic                                     match
);

  localparam int IdxW = (Win > 1) ? $clog2(Win) : 1;

  logic [Win-1:0] ok;

  // Pattern byte k lines up with window slot len-1-k, the newest byte at slot 0.
  always_comb begin
    logic [wbps_pkg::LEN_W-1:0] slot;
    logic [IdxW-1:0]            idx;
    slot = '0;
    idx  = '0;
    for (int k = 0; k < Win; k++) begin
      slot  = wbps_pkg::LEN_W'(len - wbps_pkg::LEN_W'(k + 1));
      idx   = slot[IdxW-1:0];
      ok[k] = 1'b1;
      if (wbps_pkg::LEN_W'(k) < len) begin
        ok[k] = win_rd[idx] &&
                (!care[k] || (win_bytes[idx] == pattern[8*k +: 8]));
      end
    end
  end

  assign match = &ok;

endmodule

`default_nettype wire

FILE: hdl/wildcard_byte_pattern_scan_top.sv
// An accepted byte is held in the input register; its result is loaded into the result register.
// Throughput: one byte per cycle unless the result channel stalls; the input register feeds
// the window compare and the result register in a single pass, and both stages move together.
// Back-pressure on the result channel stalls the input register after one slot.
// Reset (synchronous, rst_n low) clears the window flags, offset, found flag,
// both valid bits and the configuration registers to their documented values.
`default_nettype none

module wildcard_byte_pattern_scan_top #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  wbps_in_if.sink                            in_ch,
  wbps_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int PatCap = (MAX_PATTERN < wbps_pkg::PAT_BYTES) ? MAX_PATTERN
                                                             : wbps_pkg::PAT_BYTES;

  // Configuration registers.
  logic [wbps_pkg::WORD_W-1:0] pat_r [wbps_pkg::NUM_PWORDS];
  logic [wbps_pkg::CARE_W-1:0] care_r;
  logic [wbps_pkg::LEN_W-1:0]  plen_r;
  logic [wbps_pkg::ADDR_W-1:0] base_r;

  // Input register.
  logic                          s1_valid_r;
  logic [wbps_pkg::DATA_W-1:0]   s1_byte_r;
  logic                          s1_rd_r;
  logic                          s1_last_r;

  // Region state.
  logic [wbps_pkg::DATA_W-1:0]   win_bytes_r [PatCap];
  logic                          win_rd_r    [PatCap];
  logic [wbps_pkg::DATA_W-1:0]   win_bytes_nxt [PatCap];
  logic                          win_rd_nxt    [PatCap];
  logic [OFFSET_BITS-1:0]        offset_r;
  logic                          already_found_r;

  // Result register.
  logic                          out_valid_r;
  logic                          found_r;
  logic [wbps_pkg::ADDR_W-1:0]   addr_r;

  logic                          out_free;
  logic                          step;
  logic                          match;
  logic                          emit;
  logic [wbps_pkg::LEN_W-1:0]    len;
  logic [OFFSET_BITS-1:0]        start_off;
  logic [wbps_pkg::ADDR_W-1:0]   match_addr;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = found_r;
  assign out_ch.match_address = addr_r;

  // Length zero counts as one; longer lengths saturate at the window size.
  always_comb begin
    if (plen_r == '0) begin
      len = wbps_pkg::LEN_W'(1);
    end else if (plen_r > wbps_pkg::LEN_W'(PatCap)) begin
      len = wbps_pkg::LEN_W'(PatCap);
    end else begin
      len = plen_r;
    end
  end

  // Window as it stands once the byte in the input register is shifted in.
  always_comb begin
    win_bytes_nxt[0] = s1_byte_r;
    win_rd_nxt[0]    = s1_rd_r;
    for (int i = 1; i < PatCap; i++) begin
      win_bytes_nxt[i] = win_bytes_r[i-1];
      win_rd_nxt[i]    = win_rd_r[i-1];
    end
  end

  wbps_match #(
    .Win (PatCap)
  ) u_match (
    .win_bytes (win_bytes_nxt),
    .win_rd    (win_rd_nxt),
    .pattern   ({pat_r[3], pat_r[2], pat_r[1], pat_r[0]}),
    .care      (care_r),
    .len       (len),
    .match     (match)
  );

  assign start_off  = offset_r + OFFSET_BITS'(1) - OFFSET_BITS'(len);
  assign match_addr = base_r + wbps_pkg::ADDR_W'(start_off);
  assign emit       = !already_found_r && (match || s1_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r[0] <= '0;
      pat_r[1] <= '0;
      pat_r[2] <= '0;
      pat_r[3] <= '0;
      care_r   <= '1;
      plen_r   <= wbps_pkg::LEN_W'(1);
      base_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::REG_PATTERN_WORD0: pat_r[0] <= cfg_wdata;
        wbps_pkg::REG_PATTERN_WORD1: pat_r[1] <= cfg_wdata;
        wbps_pkg::REG_PATTERN_WORD2: pat_r[2] <= cfg_wdata;
        wbps_pkg::REG_PATTERN_WORD3: pat_r[3] <= cfg_wdata;
        wbps_pkg::REG_CARE_MASK:     care_r   <= cfg_wdata[wbps_pkg::CARE_W-1:0];
        wbps_pkg::REG_PATTERN_LEN:   plen_r   <= cfg_wdata[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_BASE_ADDRESS:  base_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_rd_r   <= in_ch.byte_readable;
      s1_last_r <= in_ch.last_byte;
    end
  end

  // Window bytes need no clearing: a slot whose readable flag is low never matches.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PatCap; i++) begin
        win_rd_r[i] <= 1'b0;
      end
      offset_r        <= '0;
      already_found_r <= 1'b0;
    end else if (step) begin
      for (int i = 0; i < PatCap; i++) begin
        win_rd_r[i] <= win_rd_nxt[i] && !s1_last_r;
      end
      if (s1_last_r) begin
        offset_r        <= '0;
        already_found_r <= 1'b0;
      end else begin
        offset_r        <= offset_r + OFFSET_BITS'(1);
        already_found_r <= already_found_r || match;
      end
    end
    if (step) begin
      for (int i = 0; i < PatCap; i++) begin
        win_bytes_r[i] <= win_bytes_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && emit;
    end
    if (step && emit) begin
      found_r <= match;
      addr_r  <= match ? match_addr : '0;
    end
  end

`include "wildcard_byte_pattern_scan_top_macros.svh"

  `WBPS_ASSERT_SAME(a_notfound_zero_addr, clk, rst_n, out_valid_r && !found_r, addr_r == '0)
  `WBPS_ASSERT_NEXT(a_found_latches, clk, rst_n, step && match && !s1_last_r, already_found_r)
  `WBPS_ASSERT_NEXT(a_region_clears, clk, rst_n, step && s1_last_r, (offset_r == '0) && !already_found_r)
  `WBPS_ASSERT_NEXT(a_silent_after_found, clk, rst_n, already_found_r && out_free, !out_valid_r)

endmodule

`default_nettype wire

FILE: test/wildcard_byte_pattern_scan_top_tb.sv
// Testbench for the wildcard byte pattern scan: streams regions and checks every result.
`default_nettype none

module wildcard_byte_pattern_scan_top_tb;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES  = 1450;
  localparam int RANDOM_SETS   = 12;

  typedef struct packed {
    logic [wbps_pkg::DATA_W-1:0] data;
    logic                        readable;
    logic                        last;
  } scan_byte_t;

  typedef struct packed {
    logic                        found;
    logic [wbps_pkg::ADDR_W-1:0] addr;
  } scan_hit_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata;

  wbps_in_if  in_ch ();
  wbps_out_if out_ch ();

  wildcard_byte_pattern_scan_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted copy of the configuration and the scan state.
  logic [wbps_pkg::WORD_W-1:0]          pat_word [wbps_pkg::NUM_PWORDS];
  logic [wbps_pkg::CARE_W-1:0]          care_bits;
  logic [wbps_pkg::LEN_W-1:0]           len_reg;
  logic [wbps_pkg::ADDR_W-1:0]          base_reg;
  logic [wbps_pkg::DATA_W-1:0]          win_data [wbps_pkg::PAT_BYTES];
  bit                                   win_ok [wbps_pkg::PAT_BYTES];
  logic [wbps_pkg::OFFSET_BITS_DEF-1:0] scan_offset;
  bit                                   hit_seen;

  scan_byte_t pending_bytes[$];
  scan_hit_t  hits_due[$];

  bit steady;
  bit in_taken;
  int err_count;
  int cycle_count;
  int bytes_taken;
  int match_count;
  int miss_count;
  int setting_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_len();
    int n;
    n = len_reg;
    if (n == 0) n = 1;
    if (n > wbps_pkg::PAT_BYTES) n = wbps_pkg::PAT_BYTES;
    return n;
  endfunction

  function automatic logic [wbps_pkg::DATA_W-1:0] pattern_at(int k);
    return pat_word[k >> 3][(k & 7) * 8 +: 8];
  endfunction

  function automatic void clear_region();
    for (int i = 0; i < wbps_pkg::PAT_BYTES; i++) begin
      win_data[i] = '0;
      win_ok[i]   = 1'b0;
    end
    scan_offset = '0;
    hit_seen    = 1'b0;
  endfunction

  // Shifts one byte into the window and works out the result it causes, if any.
  function automatic void scan_step(input scan_byte_t b, output bit produced,
                                    output scan_hit_t hit);
    int n;
    int slot;
    bit ok;
    logic [wbps_pkg::OFFSET_BITS_DEF-1:0] start;
    n        = active_len();
    ok       = 1'b1;
    produced = 1'b0;
    hit      = '0;
    for (int i = wbps_pkg::PAT_BYTES - 1; i > 0; i--) begin
      win_data[i] = win_data[i-1];
      win_ok[i]   = win_ok[i-1];
    end
    win_data[0] = b.data;
    win_ok[0]   = b.readable;
    for (int k = 0; k < n; k++) begin
      slot = n - 1 - k;
      if (!win_ok[slot] || (care_bits[k] && win_data[slot] != pattern_at(k))) begin
        ok = 1'b0;
        break;
      end
    end
    if (!hit_seen) begin
      if (ok) begin
        start     = scan_offset + 1'b1 - wbps_pkg::OFFSET_BITS_DEF'(n);
        hit.found = 1'b1;
        hit.addr  = base_reg + wbps_pkg::ADDR_W'(start);
        hit_seen  = 1'b1;
        produced  = 1'b1;
      end else if (b.last) begin
        produced = 1'b1;
      end
    end
    scan_offset = scan_offset + 1'b1;
    if (b.last) clear_region();
  endfunction

  task automatic report(string what);
    err_count++;
    if (err_count <= 30) $display("ERROR at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic set_reg(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                         input logic [wbps_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      wbps_pkg::REG_PATTERN_WORD0: pat_word[0] = val;
      wbps_pkg::REG_PATTERN_WORD1: pat_word[1] = val;
      wbps_pkg::REG_PATTERN_WORD2: pat_word[2] = val;
      wbps_pkg::REG_PATTERN_WORD3: pat_word[3] = val;
      wbps_pkg::REG_CARE_MASK:     care_bits   = val[wbps_pkg::CARE_W-1:0];
      wbps_pkg::REG_PATTERN_LEN:   len_reg     = val[wbps_pkg::LEN_W-1:0];
      wbps_pkg::REG_BASE_ADDRESS:  base_reg    = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [63:0] w0, input logic [63:0] w1,
                             input logic [63:0] w2, input logic [63:0] w3,
                             input logic [63:0] care, input logic [63:0] len,
                             input logic [63:0] base);
    set_reg(wbps_pkg::REG_PATTERN_WORD0, w0);
    set_reg(wbps_pkg::REG_PATTERN_WORD1, w1);
    set_reg(wbps_pkg::REG_PATTERN_WORD2, w2);
    set_reg(wbps_pkg::REG_PATTERN_WORD3, w3);
    set_reg(wbps_pkg::REG_CARE_MASK, care);
    set_reg(wbps_pkg::REG_PATTERN_LEN, len);
    set_reg(wbps_pkg::REG_BASE_ADDRESS, base);
    @(negedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  // The block may still hold a byte that causes no result, so let it settle before checking again.
  task automatic wait_idle();
    do begin
      while (pending_bytes.size() != 0 || in_ch.valid || hits_due.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
    end while (pending_bytes.size() != 0 || in_ch.valid || hits_due.size() != 0);
  endtask

  task automatic add_byte(input logic [7:0] d, input logic r, input logic l);
    scan_byte_t b;
    b.data     = d;
    b.readable = r;
    b.last     = l;
    pending_bytes.push_back(b);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Draws bytes from the pattern often, so that near misses and accidental matches occur.
  function automatic logic [7:0] noise_byte(int n);
    if ($urandom_range(0, 2) == 0) return pattern_at($urandom_range(0, n - 1));
    return 8'($urandom);
  endfunction

  task automatic random_config(int p);
    logic [63:0] care;
    logic [63:0] len;
    logic [63:0] base;
    care = {$urandom, $urandom};
    len  = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0:       care[31:0] = '0;
      1:       care[31:0] = '1;
      2:       care[31:0] = 32'hFFFF_FFFE;
      default: ;
    endcase
    case ($urandom_range(0, 6))
      0:       len[5:0] = 6'd0;
      1:       len[5:0] = 6'd1;
      2:       len[5:0] = 6'd32;
      3:       ;
      default: len[5:0] = 6'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = '1;
      2:       base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
      default: base = {$urandom, $urandom};
    endcase
    // The first sets pin the length and mask extremes.
    case (p)
      0: begin
        len[5:0]   = 6'd63;
        care[31:0] = '1;
      end
      1: begin
        len[5:0]   = 6'd0;
        care[31:0] = '0;
      end
      2: begin
        len[5:0]   = 6'd32;
        care[31:0] = 32'hFFFF_FFFE;
        base       = '1;
      end
      default: ;
    endcase
    load_config(rand_word(), rand_word(), rand_word(), rand_word(), care, len, base);
  endtask

  // One region: mostly a planted pattern inside random bytes, sometimes broken or short.
  task automatic make_region(inout int count);
    int n;
    int kind;
    int pre;
    int post;
    int total;
    int bad;
    logic [7:0] d;
    logic r;
    n     = active_len();
    kind  = $urandom_range(0, 9);
    pre   = $urandom_range(0, 12);
    post  = $urandom_range(0, 6);
    bad   = $urandom_range(0, n - 1);
    total = pre + n + post;
    if (kind == 9) total = $urandom_range(1, 3);
    else if (kind == 8) total = $urandom_range(1, n + 10);
    for (int i = 0; i < total; i++) begin
      d = noise_byte(n);
      r = ($urandom_range(0, 99) >= 3);
      if (kind == 8) begin
        r = $urandom_range(0, 1);
      end else if (kind < 8 && i >= pre && i < pre + n) begin
        r = 1'b1;
        if (care_bits[i-pre]) d = pattern_at(i - pre);
        if (kind >= 6 && i - pre == bad) begin
          if (care_bits[bad] && $urandom_range(0, 1)) d = d ^ (8'd1 << $urandom_range(0, 7));
          else r = 1'b0;
        end
      end
      add_byte(d, r, i == total - 1);
    end
    count += total;
  endtask

  always @(posedge clk) begin : monitor
    scan_hit_t want;
    scan_hit_t hit;
    bit produced;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (hits_due.size() == 0) begin
          report($sformatf("result found=%0b address=%h with nothing expected",
                           out_ch.found, out_ch.match_address));
        end else begin
          want = hits_due.pop_front();
          if (out_ch.found !== want.found)
            report($sformatf("found flag %b, expected %b", out_ch.found, want.found));
          if (out_ch.match_address !== want.addr)
            report($sformatf("address %h, expected %h", out_ch.match_address, want.addr));
          if (want.found) match_count++;
          else miss_count++;
        end
      end
      if (in_taken) begin
        scan_step('{in_ch.data_byte, in_ch.byte_readable, in_ch.last_byte}, produced, hit);
        if (produced) hits_due.push_back(hit);
        bytes_taken++;
      end
    end
  end

  always @(negedge clk) begin : driver
    scan_byte_t b;
    if (!in_ch.valid || in_taken) begin
      if (pending_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
        b = pending_bytes.pop_front();
        in_ch.data_byte     <= b.data;
        in_ch.byte_readable <= b.readable;
        in_ch.last_byte     <= b.last;
        in_ch.valid         <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, hits_due.size());
      $display("wildcard_byte_pattern_scan_top: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int fill;
    rst_n               = 1'b0;
    steady              = 1'b0;
    in_taken            = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.byte_readable = 1'b0;
    in_ch.last_byte     = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = wbps_pkg::REG_PATTERN_WORD0;
    cfg_wdata           = '0;
    for (int i = 0; i < wbps_pkg::NUM_PWORDS; i++) pat_word[i] = '0;
    care_bits = '1;
    len_reg   = wbps_pkg::LEN_W'(1);
    base_reg  = '0;
    clear_region();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a one-byte pattern of zero, hit behind an unreadable zero, then a miss.
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b1);
    add_byte(8'hFF, 1'b1, 1'b1);
    wait_idle();

    // Four bytes with a leading wildcard, base at the top of the address space.
    load_config(64'h0000_0000_5AA5_FF00, '0, '0, '0, 64'hFFFF_FFFE, 64'd4, '1);
    add_byte(8'h33, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'hA5, 1'b1, 1'b0);
    add_byte(8'h5A, 1'b1, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b1);
    // A region shorter than the pattern cannot match.
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'hA5, 1'b1, 1'b0);
    add_byte(8'h5A, 1'b1, 1'b1);
    // Match that ends on the last byte; its address wraps to zero.
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'hA5, 1'b1, 1'b0);
    add_byte(8'h5A, 1'b1, 1'b1);
    // An unreadable byte inside the match breaks it.
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hA5, 1'b1, 1'b0);
    add_byte(8'h5A, 1'b1, 1'b1);

    for (int p = 0; p < RANDOM_SETS; p++) begin
      wait_idle();
      random_config(p);
      steady = (p == 5);
      fill   = 0;
      while (fill < RANDOM_BYTES / RANDOM_SETS) make_region(fill);
    end
    wait_idle();
    steady = 1'b0;

    if (hits_due.size() != 0) report($sformatf("%0d results never arrived", hits_due.size()));
    $display("Scanned %0d bytes under %0d register settings:",
             bytes_taken, setting_count);
    $display("%0d matches and %0d region misses checked.", match_count, miss_count);
    if (err_count == 0) begin
      $display("wildcard_byte_pattern_scan_top: match");
    end else begin
      $display("wildcard_byte_pattern_scan_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
